### hw/rtl/bpxm_pkg.sv
// ----------------------------------------------------------------------------
// Byte permute and mask cipher package
// Widths, reset values, register indexes, item types and the mask function
// shared by the modules of the byte permute and mask cipher.
// ----------------------------------------------------------------------------
package bpxm_pkg;

  localparam int CFG_W          = 16;
  localparam int KEY_W          = 16;
  localparam int IDX_W          = 16;
  localparam int DATA_W         = 8;
  localparam int OUT_ADDR_W     = 16;
  localparam int ADDR_WIDTH_DEF = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 16'd65521;
  localparam logic [CFG_W-1:0] CIPHER_KEY_RST = 16'd3;

  // Remainder bits resolved by each stage of a modulo pipeline.
  localparam int STEP_N = 2;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 1'b0,
    REG_CIPHER_KEY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last;
    logic              range_err;
  } item_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] masked;
    logic              last;
    logic              range_err;
  } out_side_t;

  function automatic logic [DATA_W-1:0] mix_lo8(input logic [63:0] v_in);
    logic [63:0] v;
    v = v_in ^ (v_in << SHIFT_A);
    v = v ^ (v >> SHIFT_B);
    v = v ^ (v << SHIFT_C);
    return v[DATA_W-1:0];
  endfunction

endpackage

### hw/rtl/bpxm_in_if.sv
// ----------------------------------------------------------------------------
// Byte permute and mask cipher input channel
// Valid and ready handshake carrying the byte index, data byte and last flag.
// ----------------------------------------------------------------------------
interface bpxm_in_if
  import bpxm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  byte_index;
  logic [DATA_W-1:0] data_byte;
  logic              last_in;

  modport source (output valid, output byte_index, output data_byte, output last_in,
                  input ready);
  modport sink   (input valid, input byte_index, input data_byte, input last_in,
                  output ready);
endinterface

### hw/rtl/bpxm_out_if.sv
// ----------------------------------------------------------------------------
// Byte permute and mask cipher result channel
// Valid and ready handshake with address, mask, masked byte, error and last.
// ----------------------------------------------------------------------------
interface bpxm_out_if
  import bpxm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] permuted_address;
  logic [DATA_W-1:0]     mask_byte;
  logic [DATA_W-1:0]     masked_byte;
  logic                  range_error;
  logic                  last_out;

  modport source (output valid, output permuted_address, output mask_byte,
                  output masked_byte, output range_error, output last_out,
                  input ready);
  modport sink   (input valid, input permuted_address, input mask_byte,
                  input masked_byte, input range_error, input last_out,
                  output ready);
endinterface

### hw/rtl/byte_permute_xorshift_mask_cipher.sv
// ----------------------------------------------------------------------------
// Byte permute and mask cipher
// Maps a byte index to a scrambled address and a keystream mask byte.
//
// Requests arrive on in_ch (byte index, data byte, last flag) and results
// leave on out_ch (address, mask, masked byte, range error, last flag), both
// with valid and ready. Block size and key are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no request is in
// flight, as the block does not enforce it. One request is accepted every
// cycle unless a stall has filled every stage. The two modulo pipelines
// each resolve two remainder bits per stage.
// Reset empties every stage and loads a block size of 65521 and a key of 3.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// drops in_ch.ready only once no stage is free; nothing is lost or repeated.
// An index at or beyond the block size gives range_error with zero address,
// mask and masked byte.
// ----------------------------------------------------------------------------
module byte_permute_xorshift_mask_cipher
  import bpxm_pkg::*;
#(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bpxm_in_if.sink              in_ch,
  bpxm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SUM_W  = ((ADDR_WIDTH > KEY_W) ? ADDR_WIDTH : KEY_W) + 1;
  localparam int PROD_W = ADDR_WIDTH + KEY_W;

  logic [CFG_W-1:0]      block_size_r;
  logic [KEY_W-1:0]      cipher_key_r;

  logic [ADDR_WIDTH-1:0] idx;
  logic [ADDR_WIDTH-1:0] size;

  logic                  in_v_r;
  logic [SUM_W-1:0]      sum_r;
  item_side_t            in_side_r;

  logic                  p1_in_ready;
  logic                  p1_out_valid;
  logic [ADDR_WIDTH-1:0] p1_rem;
  item_side_t            p1_side;

  logic                  mx_in_ready;
  logic                  mx_out_valid;
  logic [PROD_W-1:0]     mx_prod;
  out_side_t             mx_side;

  logic                  p2_in_ready;
  logic [ADDR_WIDTH-1:0] p2_rem;
  out_side_t             p2_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      cipher_key_r <= CIPHER_KEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIZE: block_size_r <= cfg_data;
        REG_CIPHER_KEY: cipher_key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx  = ADDR_WIDTH'(in_ch.byte_index);
  assign size = ADDR_WIDTH'(block_size_r);

  assign in_ch.ready = !in_v_r || p1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      sum_r               <= SUM_W'(idx) + SUM_W'(cipher_key_r);
      in_side_r.data_byte <= in_ch.data_byte;
      in_side_r.last      <= in_ch.last_in;
      in_side_r.range_err <= (idx >= size);
    end
  end

  bpxm_mod_pipe #(
    .NUM_W  (SUM_W),
    .DEN_W  (ADDR_WIDTH),
    .SIDE_W ($bits(item_side_t))
  ) u_mod_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_v_r),
    .in_ready  (p1_in_ready),
    .in_num    (sum_r),
    .in_side   (in_side_r),
    .den       (size),
    .out_valid (p1_out_valid),
    .out_ready (mx_in_ready),
    .out_rem   (p1_rem),
    .out_side  (p1_side)
  );

  bpxm_mix #(
    .ADDR_W (ADDR_WIDTH)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_out_valid),
    .in_ready  (mx_in_ready),
    .in_rem    (p1_rem),
    .in_side   (p1_side),
    .key       (cipher_key_r),
    .out_valid (mx_out_valid),
    .out_ready (p2_in_ready),
    .out_prod  (mx_prod),
    .out_side  (mx_side)
  );

  bpxm_mod_pipe #(
    .NUM_W  (PROD_W),
    .DEN_W  (ADDR_WIDTH),
    .SIDE_W ($bits(out_side_t))
  ) u_mod_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mx_out_valid),
    .in_ready  (p2_in_ready),
    .in_num    (mx_prod),
    .in_side   (mx_side),
    .den       (size),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rem   (p2_rem),
    .out_side  (p2_side)
  );

  assign out_ch.permuted_address = OUT_ADDR_W'(p2_rem);
  assign out_ch.mask_byte        = p2_side.mask;
  assign out_ch.masked_byte      = p2_side.masked;
  assign out_ch.range_error      = p2_side.range_err;
  assign out_ch.last_out         = p2_side.last;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input refused with an empty output stage");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |->
      (out_ch.permuted_address == '0) && (out_ch.mask_byte == '0) &&
      (out_ch.masked_byte == '0))
    else $error("range error result carries non-zero fields");

endmodule

### hw/rtl/bpxm_mod_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined modulo unit
// Restoring remainder calculation, a fixed number of numerator bits per
// stage, with a valid bit and side data travelling alongside each request.
// ----------------------------------------------------------------------------
module bpxm_mod_pipe
  import bpxm_pkg::*;
#(
  parameter int NUM_W  = 17,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  den,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NSTG  = (NUM_W + STEP_N - 1) / STEP_N;
  localparam int PAD_W = NSTG * STEP_N;

  logic              v_r    [NSTG];
  logic              rdy    [NSTG+1];
  logic [DEN_W-1:0]  rem_r  [NSTG];
  logic [PAD_W-1:0]  num_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic              prev_v;
    logic [DEN_W-1:0]  prev_rem;
    logic [PAD_W-1:0]  prev_num;
    logic [SIDE_W-1:0] prev_side;
    logic [DEN_W-1:0]  rem_nxt;

    if (g == 0) begin : g_head
      assign prev_v    = in_valid;
      assign prev_rem  = '0;
      assign prev_num  = PAD_W'(in_num);
      assign prev_side = in_side;
    end else begin : g_body
      assign prev_v    = v_r[g-1];
      assign prev_rem  = rem_r[g-1];
      assign prev_num  = num_r[g-1];
      assign prev_side = side_r[g-1];
    end

    always_comb begin : step
      logic [DEN_W:0] acc;
      acc     = '0;
      rem_nxt = prev_rem;
      for (int k = 0; k < STEP_N; k++) begin
        acc = {rem_nxt, prev_num[PAD_W-1-k]};
        if (acc >= {1'b0, den}) begin
          acc = acc - {1'b0, den};
        end
        rem_nxt = acc[DEN_W-1:0];
      end
    end

    assign rdy[g] = !v_r[g] || rdy[g+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && prev_v) begin
        rem_r[g]  <= rem_nxt;
        num_r[g]  <= prev_num << STEP_N;
        side_r[g] <= prev_side;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_rem   = rem_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (den != '0) |-> out_rem < den)
    else $error("remainder not below divisor");

endmodule

### hw/rtl/bpxm_mix.sv
// ----------------------------------------------------------------------------
// Product and mask stages
// Multiplies the reduced index plus key by the key, then forms the xorshift
// mask and masked byte, zeroing the product and both bytes when out of range.
// ----------------------------------------------------------------------------
module bpxm_mix
  import bpxm_pkg::*;
#(
  parameter int ADDR_W = ADDR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADDR_W-1:0]       in_rem,
  input  item_side_t              in_side,
  input  logic [KEY_W-1:0]        key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADDR_W+KEY_W-1:0] out_prod,
  output out_side_t               out_side
);

  localparam int PROD_W = ADDR_W + KEY_W;

  logic              a_v_r;
  logic [PROD_W-1:0] a_prod_r;
  item_side_t        a_side_r;
  logic              a_rdy;

  logic              b_v_r;
  logic [PROD_W-1:0] b_prod_r;
  out_side_t         b_side_r;
  logic              b_rdy;
  logic [DATA_W-1:0] mask_nxt;

  assign b_rdy    = !b_v_r || out_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_prod_r <= PROD_W'(in_rem) * PROD_W'(key);
      a_side_r <= in_side;
    end
  end

  assign mask_nxt = mix_lo8(64'(a_prod_r));

  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r) begin
      b_side_r.last      <= a_side_r.last;
      b_side_r.range_err <= a_side_r.range_err;
      if (a_side_r.range_err) begin
        b_prod_r        <= '0;
        b_side_r.mask   <= '0;
        b_side_r.masked <= '0;
      end else begin
        b_prod_r        <= a_prod_r;
        b_side_r.mask   <= mask_nxt;
        b_side_r.masked <= a_side_r.data_byte ^ mask_nxt;
      end
    end
  end

  assign out_valid = b_v_r;
  assign out_prod  = b_prod_r;
  assign out_side  = b_side_r;

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_side.range_err |-> (out_prod == '0) && (out_side.masked == '0))
    else $error("out-of-range request not cleared");

endmodule
